// ----- hdl/hsec_pkg.sv -----
// package for the hamming single-error-correcting decoder
// holds field widths, status flags type and code length helpers; no dependencies
package hsec_pkg;

    // fixed field widths of the stream payload
    localparam int CODEWORD_W     = 63;
    localparam int DATA_BITS_W    = 57;
    localparam int SYNDROME_W     = 6;
    localparam int DATA_LEN_W     = 6;
    localparam int S_TDATA_W      = 64;
    localparam int M_TDATA_W      = 72;

    // defaults
    localparam int CODE_BITS_DEFAULT = 63;
    localparam logic [DATA_LEN_W-1:0] DATA_LEN_RESET = 6'd4;

    // status that travels with each decoded word
    typedef struct packed {
        logic corrected;
        logic out_of_range;
    } hsec_flags_t;

    // least r with 2^r >= m + r + 1
    function automatic logic [2:0] parity_count(input logic [DATA_LEN_W-1:0] m);
        logic [2:0] r;
        logic       found;
        r     = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && ((8'd1 << i) >= ({2'b00, m} + 8'(i) + 8'd1))) begin
                r     = 3'(i);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    // largest data length whose code still fits in code_bits positions
    function automatic int max_data_len(input int code_bits);
        int best;
        best = 0;
        for (int m = 0; m < 64; m++) begin
            if (m + int'(parity_count(6'(m))) <= code_bits) begin
                best = m;
            end
        end
        return best;
    endfunction

    // code length n for data length m, with m clamped to max_m
    function automatic logic [5:0] code_length(input logic [DATA_LEN_W-1:0] m,
                                               input logic [DATA_LEN_W-1:0] max_m);
        logic [DATA_LEN_W-1:0] mc;
        mc = (m > max_m) ? max_m : m;
        return 6'(7'(mc) + 7'(parity_count(mc)));
    endfunction

endpackage

// ----- hdl/hamming_single_error_correct.sv -----
// Hamming single-error-correcting decoder, top level.
// One codeword per transfer on the slave stream, one decoded result per transfer on the
// master stream. The data length register sets the parity count r (least r with
// 2^r >= m+r+1) and the code length n = m+r; lengths whose code would not fit in
// CODE_BITS positions are lowered to the largest that fits. Codeword bits above n are
// ignored. The syndrome flips one bit when it lies in 1..n; above n the word passes
// uncorrected with syndrome_out_of_range set. Results pass the input register, then the
// result register; a new codeword is taken every cycle while the master stream is not
// stalled. The single syndrome xor tree and compaction sit between the two registers.
// Write the data length only while no transfer is in flight.
// depends on hsec_pkg, hsec_syndrome, hsec_extract
module hamming_single_error_correct
    import hsec_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [DATA_LEN_W-1:0]  cfg_wr_data,   // data_length
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,       // [62:0] codeword, [63] zero
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata        // [56:0] data_bits, [62:57] syndrome,
                                                  // [63] corrected,
                                                  // [64] syndrome_out_of_range, [71:65] zero
);

    localparam int SYN_W  = $clog2(CODE_BITS + 1);
    localparam int DATA_W = CODE_BITS - $clog2(CODE_BITS + 1);
    localparam logic [DATA_LEN_W-1:0] MAX_M = DATA_LEN_W'(max_data_len(CODE_BITS));
    localparam logic [SYN_W-1:0] CODE_LEN_RESET =
        SYN_W'(code_length(DATA_LEN_RESET, MAX_M));

    logic [SYN_W-1:0]     code_len_reg, code_len_next;
    logic                 in_valid_reg;
    logic [CODE_BITS-1:0] cw_reg, cw_next;
    logic                 m_valid_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [SYN_W-1:0]     syn_reg;
    hsec_flags_t          flags_reg;

    logic                 out_free;
    logic                 in_adv;
    logic                 s_xfer;
    logic [SYN_W-1:0]     syn;
    hsec_flags_t          flags;
    logic [CODE_BITS-1:0] cw_fixed;
    logic [DATA_W-1:0]    data;

    // configuration: keep the derived code length
    assign code_len_next = SYN_W'(code_length(cfg_wr_data, MAX_M));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_len_reg <= CODE_LEN_RESET;
        end else if (cfg_wr_en) begin
            code_len_reg <= code_len_next;
        end
    end

    // handshake: result stage frees up when empty or taken
    assign out_free = !m_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;

    // input register, bits beyond the code length cleared
    always_comb begin
        for (int i = 0; i < CODE_BITS; i++) begin
            cw_next[i] = s_tdata[i] && (SYN_W'(i) < code_len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cw_reg <= cw_next;
        end
    end

    // decode between the two registers
    hsec_syndrome #(
        .CODE_BITS (CODE_BITS),
        .SYN_W     (SYN_W)
    ) u_syndrome (
        .cw        (cw_reg),
        .code_len  (code_len_reg),
        .syndrome  (syn),
        .flags     (flags),
        .cw_fixed  (cw_fixed)
    );

    hsec_extract #(
        .CODE_BITS (CODE_BITS),
        .DATA_W    (DATA_W)
    ) u_extract (
        .cw        (cw_fixed),
        .data      (data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            data_reg  <= data;
            syn_reg   <= syn;
            flags_reg <= flags;
        end
    end

    // output packing
    assign m_tvalid = m_valid_reg;
    always_comb begin
        m_tdata = '0;
        m_tdata[DATA_BITS_W-1:0] = DATA_BITS_W'(data_reg);
        m_tdata[DATA_BITS_W +: SYNDROME_W] = SYNDROME_W'(syn_reg);
        m_tdata[DATA_BITS_W + SYNDROME_W]     = flags_reg.corrected;
        m_tdata[DATA_BITS_W + SYNDROME_W + 1] = flags_reg.out_of_range;
    end

    // a corrected word never reports an out-of-range syndrome
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(flags_reg.corrected && flags_reg.out_of_range))
        else $error("corrected and out-of-range both set");

    // zero syndrome means nothing flagged
    a_zero_syndrome: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && syn_reg == '0) |-> (!flags_reg.corrected && !flags_reg.out_of_range))
        else $error("flags set with zero syndrome");

    // out-of-range flag agrees with the code length
    a_range_check: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (flags_reg.out_of_range == (syn_reg > code_len_reg)))
        else $error("out-of-range flag disagrees with code length");

    // a stalled input stage keeps its word
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(cw_reg)))
        else $error("input stage lost a word while stalled");

endmodule

// ----- hdl/hsec_syndrome.sv -----
// syndrome computation and single-bit correction for one codeword
// depends on hsec_pkg
module hsec_syndrome
    import hsec_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEFAULT,
    parameter int SYN_W     = $clog2(CODE_BITS + 1)
) (
    input  logic [CODE_BITS-1:0] cw,        // bits above code length already cleared
    input  logic [SYN_W-1:0]     code_len,
    output logic [SYN_W-1:0]     syndrome,
    output hsec_flags_t          flags,
    output logic [CODE_BITS-1:0] cw_fixed
);

    logic flip_en;

    // xor of the positions of all set bits
    always_comb begin
        syndrome = '0;
        for (int j = 1; j <= CODE_BITS; j++) begin
            if (cw[j-1]) begin
                syndrome = syndrome ^ SYN_W'(j);
            end
        end
    end

    // classify the syndrome
    always_comb begin
        flags.out_of_range = (syndrome > code_len);
        flags.corrected    = (syndrome != '0) && !flags.out_of_range;
        flip_en            = flags.corrected;
    end

    // flip the bit at the syndrome position
    always_comb begin
        for (int i = 0; i < CODE_BITS; i++) begin
            cw_fixed[i] = cw[i] ^ (flip_en && (syndrome == SYN_W'(i + 1)));
        end
    end

endmodule

// ----- hdl/hsec_extract.sv -----
// packs the non-parity code positions, in ascending order, into the data word
// depends on hsec_pkg
module hsec_extract
    import hsec_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEFAULT,
    parameter int DATA_W    = CODE_BITS - $clog2(CODE_BITS + 1)
) (
    input  logic [CODE_BITS-1:0] cw,
    output logic [DATA_W-1:0]    data
);

    // position j (not a power of two) lands in data bit j - 1 - clog2(j + 1)
    for (genvar j = 1; j <= CODE_BITS; j++) begin : g_pos
        if ((j & (j - 1)) != 0) begin : g_data
            assign data[j - 1 - $clog2(j + 1)] = cw[j-1];
        end
    end

endmodule

// ----- tb/tb_hamming_single_error_correct.sv -----
// self-checking testbench for the hamming single-error-correcting decoder
// streams codewords through the block and compares each result with an in-bench decoder
// depends on hsec_pkg and hamming_single_error_correct
`timescale 1ns / 100ps

module tb_hamming_single_error_correct
    import hsec_pkg::*;
();

    localparam int CODE_LEN    = CODE_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [DATA_BITS_W-1:0] data_bits;
        logic [SYNDROME_W-1:0]  syndrome;
        logic                   corrected;
        logic                   out_of_range;
    } decoded_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [DATA_LEN_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    // codewords waiting to be sent, decoded words waiting to come back
    logic [CODEWORD_W-1:0] codeword_q[$];
    decoded_t              decoded_q[$];

    logic [DATA_LEN_W-1:0] cur_len;
    logic                  s_took;
    logic                  idle_on;
    logic                  tx_valid_nxt;
    logic                  rx_rdy_nxt;
    decoded_t              exp_word;
    int                    tx_gap;
    int                    rx_gap;
    int                    rx_long_left;
    int                    long_hold_at;
    logic                  long_hold_done;
    int                    in_total;
    int                    mismatches;
    int                    cycle_cnt;

    hamming_single_error_correct DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // least r with 2^r >= m + r + 1
    function automatic int check_bits(input int m);
        int r;
        r = 0;
        while ((1 << r) < m + r + 1) r++;
        return r;
    endfunction

    // code length after lowering m until the code fits
    function automatic int code_len(input logic [DATA_LEN_W-1:0] len);
        int m;
        m = int'(len);
        while (m > 0 && m + check_bits(m) > CODE_LEN) m--;
        return m + check_bits(m);
    endfunction

    // place data at non-power-of-two positions and fill the parity positions
    function automatic logic [CODEWORD_W-1:0] hamming_encode(input logic [DATA_BITS_W-1:0] payload,
                                                             input logic [DATA_LEN_W-1:0] len);
        logic [CODEWORD_W-1:0] cw;
        int n, k, syn;
        cw  = '0;
        n   = code_len(len);
        k   = 0;
        syn = 0;
        for (int j = 1; j <= n; j++) begin
            if ((j & (j - 1)) != 0) begin
                cw[j-1] = payload[k];
                if (payload[k]) syn ^= j;
                k++;
            end
        end
        for (int j = 1; j <= n; j = j * 2) begin
            if ((syn & j) != 0) cw[j-1] = 1'b1;
        end
        return cw;
    endfunction

    // syndrome, single-bit fix and data compaction
    function automatic decoded_t hamming_decode(input logic [CODEWORD_W-1:0] cw_in,
                                                input logic [DATA_LEN_W-1:0] len);
        decoded_t              res;
        logic [CODEWORD_W-1:0] cw;
        int n, syn, k;
        res = '0;
        cw  = cw_in;
        n   = code_len(len);
        syn = 0;
        for (int j = 1; j <= n; j++) begin
            if (cw[j-1]) syn ^= j;
        end
        if (syn > n) begin
            res.out_of_range = 1'b1;
        end else if (syn != 0) begin
            cw[syn-1]     = ~cw[syn-1];
            res.corrected = 1'b1;
        end
        res.syndrome = SYNDROME_W'(syn);
        k = 0;
        for (int j = 1; j <= n; j++) begin
            if ((j & (j - 1)) != 0) begin
                res.data_bits[k] = cw[j-1];
                k++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("cycle %0d: %s mismatch, got %0h expected %0h", cycle_cnt, what, got, want);
        mismatches++;
    endtask

    // change data length once the block has drained
    task automatic write_length(input logic [DATA_LEN_W-1:0] len);
        while (codeword_q.size() != 0 || decoded_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_len = len;
        @(posedge aclk);
    endtask

    // mostly valid codewords with random data, some with errors, some noise
    task automatic push_random(input int count);
        logic [CODEWORD_W-1:0] cw;
        logic [63:0]           payload;
        logic [63:0]           noise;
        int n, kind;
        n = code_len(cur_len);
        repeat (count) begin
            payload = {$urandom, $urandom};
            noise   = {$urandom, $urandom};
            kind    = $urandom_range(0, 9);
            cw      = hamming_encode(payload[DATA_BITS_W-1:0], cur_len);
            if (kind <= 4 && n > 0) begin
                cw[$urandom_range(1, n) - 1] ^= 1'b1;
            end else if (kind == 7 && n > 0) begin
                cw[$urandom_range(1, n) - 1] ^= 1'b1;
                cw[$urandom_range(1, n) - 1] ^= 1'b1;
            end else if (kind == 8) begin
                cw = noise[CODEWORD_W-1:0];
            end else if (kind == 9) begin
                cw |= noise[CODEWORD_W-1:0] & ~((63'd1 << n) - 63'd1);
            end
            codeword_q.push_back(cw);
        end
    endtask

    // sender: hold valid until the transfer, then next item or an idle burst
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_took) codeword_q.delete(0);
            tx_valid_nxt = s_tvalid && !s_took;
            if (!tx_valid_nxt) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(1, 12) - 1;
                end else if (codeword_q.size() > 0) begin
                    tx_valid_nxt = 1'b1;
                    s_tdata <= {1'b0, codeword_q[0]};
                end
            end
            s_tvalid <= tx_valid_nxt;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            rx_rdy_nxt = 1'b1;
            if (!long_hold_done && long_hold_at > 0 && in_total >= long_hold_at) begin
                rx_long_left   = 200;
                long_hold_done = 1'b1;
            end
            if (rx_long_left > 0) begin
                rx_long_left--;
                rx_rdy_nxt = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rx_rdy_nxt = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap     = $urandom_range(1, 12) - 1;
                rx_rdy_nxt = 1'b0;
            end
            m_tready <= rx_rdy_nxt;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                decoded_q.push_back(hamming_decode(s_tdata[CODEWORD_W-1:0], cur_len));
                in_total <= in_total + 1;
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    exp_word = decoded_q.pop_front();
                    if (m_tdata[56:0] !== exp_word.data_bits)
                        report_mismatch("data_bits", 64'(m_tdata[56:0]),
                                        64'(exp_word.data_bits));
                    if (m_tdata[62:57] !== exp_word.syndrome)
                        report_mismatch("syndrome", 64'(m_tdata[62:57]),
                                        64'(exp_word.syndrome));
                    if (m_tdata[63] !== exp_word.corrected)
                        report_mismatch("corrected", 64'(m_tdata[63]),
                                        64'(exp_word.corrected));
                    if (m_tdata[64] !== exp_word.out_of_range)
                        report_mismatch("syndrome_out_of_range", 64'(m_tdata[64]),
                                        64'(exp_word.out_of_range));
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cur_len        = DATA_LEN_RESET;
        s_took         = 1'b0;
        idle_on        = 1'b1;
        tx_gap         = 0;
        rx_gap         = 0;
        rx_long_left   = 0;
        long_hold_at   = 0;
        long_hold_done = 1'b0;
        in_total       = 0;
        mismatches     = 0;
        cycle_cnt      = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default length: n = 7, clean words, flips on parity and data positions
        write_length(6'd4);
        codeword_q.push_back('0);
        codeword_q.push_back('1);
        codeword_q.push_back(hamming_encode(57'hF, cur_len));
        codeword_q.push_back(hamming_encode(57'hA, cur_len) ^ 63'h1);
        codeword_q.push_back(hamming_encode(57'hA, cur_len) ^ 63'h4);
        codeword_q.push_back(hamming_encode(57'h5, cur_len) ^ 63'h40);
        codeword_q.push_back(63'h7FFF_FFFF_FFFF_FF80);

        // n = 9: syndrome beyond the code length, last position flipped
        write_length(6'd5);
        codeword_q.push_back(hamming_encode(57'h15, cur_len) ^ 63'h120);
        codeword_q.push_back(hamming_encode(57'h0B, cur_len) ^ 63'h100);
        codeword_q.push_back(63'h7FFF_FFFF_FFFF_FF00);

        // zero data length: everything ignored
        write_length(6'd0);
        codeword_q.push_back('1);
        codeword_q.push_back(63'h2AAA_AAAA_AAAA_AAAA);

        // too long, lowered to 57 data bits over all 63 positions
        write_length(6'd63);
        codeword_q.push_back('1);
        codeword_q.push_back(hamming_encode('1, cur_len));
        codeword_q.push_back(hamming_encode('0, cur_len) ^ (63'd1 << 62));
        codeword_q.push_back(hamming_encode('0, cur_len) ^ (63'd1 << 31));
        codeword_q.push_back(63'h5555_5555_5555_5555);
        codeword_q.push_back(63'h2AAA_AAAA_AAAA_AAAA);
        write_length(6'd58);
        codeword_q.push_back(hamming_encode(57'h1AB_CDEF_0123_4567, cur_len) ^ 63'h8);

        // random part; the first phase holds the receiver off long enough to back up
        write_length(6'd57);
        long_hold_at = in_total + 40;
        push_random(200);
        write_length(6'd1);
        push_random(100);
        write_length(6'd2);
        push_random(100);
        write_length(6'd3);
        push_random(100);
        write_length(6'd11);
        push_random(100);
        write_length(6'd26);
        push_random(100);
        write_length(6'd33);
        push_random(100);
        write_length(6'($urandom_range(0, 63)));
        push_random(100);
        write_length(6'($urandom_range(0, 63)));
        push_random(100);

        // closing stretch with no idling, pending bursts dropped
        write_length(6'd4);
        idle_on = 1'b0;
        tx_gap  = 0;
        rx_gap  = 0;
        push_random(100);

        while (codeword_q.size() != 0 || decoded_q.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
